// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helpers for the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STEPS = 14;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	// radicand is at most 2^54, root at most 2^27
	localparam int RAD_W       = 55;
	localparam int ROOT_W      = 28;
	localparam int SQRT_STAGES = 28;

	typedef logic signed [31:0] term_t;
	typedef logic signed [32:0] ang_t;

	localparam term_t TERM_ONE = 32'sd134217728;   // 1.0 in product units
	localparam term_t TERM_LIM = 32'sd1073741824;  // saturation limit, 8.0
	localparam ang_t  ANG_HALF_PI = 33'sd1073741824;
	localparam ang_t  ANG_PI      = 33'sd2147483648;

	localparam logic signed [15:0] PITCH_UP   = 16'sh4000;
	localparam logic signed [15:0] PITCH_DOWN = 16'shC000;

	localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
		30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
		30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
	};

	typedef struct packed {
		logic clamp;
		logic neg;
	} pflag_t;

	typedef struct packed {
		term_t  sr;
		term_t  cr;
		term_t  sy;
		term_t  cy;
		term_t  ss;
		pflag_t flag;
	} side_t;

	function automatic term_t sat_add(term_t a, term_t b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'(TERM_LIM))
			return TERM_LIM;
		else if (s < -33'(TERM_LIM))
			return -TERM_LIM;
		else
			return term_t'(s[31:0]);
	endfunction

endpackage

// ===== hdl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  radicand,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output side_t             side_out
);

	logic [RAD_W:0] rem_s [1:SQRT_STAGES];
	logic [RAD_W:0] res_s [1:SQRT_STAGES];
	side_t          side_s [1:SQRT_STAGES];
	logic           v_s [1:SQRT_STAGES];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (SQRT_STAGES - 1 - j));
		logic [RAD_W:0] rem_c, res_c, trial;
		side_t          side_c;
		logic           v_c;
		if (j == 0) begin : g_first
			assign rem_c  = {1'b0, radicand};
			assign res_c  = '0;
			assign side_c = side_in;
			assign v_c    = in_valid;
		end else begin : g_next
			assign rem_c  = rem_s[j];
			assign res_c  = res_s[j];
			assign side_c = side_s[j];
			assign v_c    = v_s[j];
		end
		assign trial = res_c + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_c;
				if (rem_c >= trial) begin
					rem_s[j+1] <= rem_c - trial;
					res_s[j+1] <= (res_c >> 1) + BIT;
				end else begin
					rem_s[j+1] <= rem_c;
					res_s[j+1] <= res_c >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STAGES];
	assign root      = res_s[SQRT_STAGES][ROOT_W-1:0];
	assign side_out  = side_s[SQRT_STAGES];

`ifndef SYNTHESIS
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_s[SQRT_STAGES] <= (RAD_W+1)'(134217728))
		else $error("square root above one");
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_s[SQRT_STAGES][RAD_W:ROOT_W] == '0)
		else $error("square root overflows its width");
`endif

endmodule

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined atan2: magnitude, normalize, vectoring CORDIC, quadrant fix-up.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  term_t              y_in,
	input  term_t              x_in,
	input  pflag_t             flag_in,
	output logic               out_valid,
	output logic signed [15:0] angle,
	output pflag_t             flag_out
);

	// magnitudes and signs
	logic [30:0] ax_s1, ay_s1;
	logic        xneg_s1, yneg_s1, v_s1;
	pflag_t      flag_s1;

	// shift amounts
	logic [30:0] ax_s2, ay_s2;
	logic        xneg_s2, yneg_s2, zero_s2, v_s2;
	logic [1:0]  rsh_s2;
	logic [4:0]  lsh_s2;
	pflag_t      flag_s2;

	logic signed [32:0] it_cx_s [0:CORDIC_ITERS];
	logic signed [32:0] it_cy_s [0:CORDIC_ITERS];
	ang_t               it_z_s  [0:CORDIC_ITERS];
	logic               it_xneg_s [0:CORDIC_ITERS];
	logic               it_yneg_s [0:CORDIC_ITERS];
	logic               it_zero_s [0:CORDIC_ITERS];
	logic               it_v_s    [0:CORDIC_ITERS];
	pflag_t             it_flag_s [0:CORDIC_ITERS];

	ang_t   fix_z_s, fix_c;
	logic   fix_v_s;
	pflag_t fix_flag_s;

	logic signed [15:0] ang_s;
	logic               ang_v_s;
	pflag_t             ang_flag_s;

	logic [30:0] lead;
	logic [4:0]  pos;
	logic signed [33:0] rnd;

	always_comb begin
		lead = ax_s1 | ay_s1;
		pos  = '0;
		for (int b = 0; b < 31; b++) begin
			if (lead[b]) pos = 5'(b);
		end
	end

	always_comb begin
		ang_t zc;
		if (it_z_s[CORDIC_ITERS] < 0)
			zc = '0;
		else if (it_z_s[CORDIC_ITERS] > ANG_HALF_PI)
			zc = ANG_HALF_PI;
		else
			zc = it_z_s[CORDIC_ITERS];
		if (it_xneg_s[CORDIC_ITERS]) zc = ANG_PI - zc;
		if (it_yneg_s[CORDIC_ITERS]) zc = -zc;
		fix_c = it_zero_s[CORDIC_ITERS] ? '0 : zc;
	end

	assign rnd = 34'(fix_z_s) + 34'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			it_v_s[0]  <= 1'b0;
			fix_v_s    <= 1'b0;
			ang_v_s    <= 1'b0;
		end else if (en) begin
			v_s1       <= in_valid;
			v_s2       <= v_s1;
			it_v_s[0]  <= v_s2;
			fix_v_s    <= it_v_s[CORDIC_ITERS];
			ang_v_s    <= fix_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= x_in[31] ? 31'(-x_in) : x_in[30:0];
			ay_s1   <= y_in[31] ? 31'(-y_in) : y_in[30:0];
			xneg_s1 <= x_in[31];
			yneg_s1 <= y_in[31];
			flag_s1 <= flag_in;

			// bring the leading one to bit 28
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			zero_s2 <= (lead == '0);
			rsh_s2  <= (pos > 5'd28) ? 2'(pos - 5'd28) : 2'd0;
			lsh_s2  <= (pos > 5'd28) ? 5'd0 : 5'd28 - pos;
			flag_s2 <= flag_s1;

			it_cx_s[0]   <= 33'({2'b00, (ax_s2 >> rsh_s2) << lsh_s2});
			it_cy_s[0]   <= 33'({2'b00, (ay_s2 >> rsh_s2) << lsh_s2});
			it_z_s[0]    <= '0;
			it_xneg_s[0] <= xneg_s2;
			it_yneg_s[0] <= yneg_s2;
			it_zero_s[0] <= zero_s2;
			it_flag_s[0] <= flag_s2;

			fix_z_s    <= fix_c;
			fix_flag_s <= it_flag_s[CORDIC_ITERS];

			ang_s      <= rnd[31:16];
			ang_flag_s <= fix_flag_s;
		end
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		logic signed [32:0] dx, dy;
		ang_t               da;
		assign dx = it_cx_s[i] >>> i;
		assign dy = it_cy_s[i] >>> i;
		assign da = 33'({3'b000, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				it_v_s[i+1] <= 1'b0;
			end else if (en) begin
				it_v_s[i+1] <= it_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				// rotate toward the x axis, accumulate the angle
				if (!it_cy_s[i][32]) begin
					it_cx_s[i+1] <= it_cx_s[i] + dy;
					it_cy_s[i+1] <= it_cy_s[i] - dx;
					it_z_s[i+1]  <= it_z_s[i] + da;
				end else begin
					it_cx_s[i+1] <= it_cx_s[i] - dy;
					it_cy_s[i+1] <= it_cy_s[i] + dx;
					it_z_s[i+1]  <= it_z_s[i] - da;
				end
				it_xneg_s[i+1] <= it_xneg_s[i];
				it_yneg_s[i+1] <= it_yneg_s[i];
				it_zero_s[i+1] <= it_zero_s[i];
				it_flag_s[i+1] <= it_flag_s[i];
			end
		end
	end

	assign out_valid = ang_v_s;
	assign angle     = ang_s;
	assign flag_out  = ang_flag_s;

`ifndef SYNTHESIS
	a_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		fix_v_s |-> (fix_z_s <= ANG_PI && fix_z_s >= -ANG_PI))
		else $error("fixed-up angle out of range");
`endif

endmodule

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Attitude quaternion (Q2.14) in, ZYX roll/pitch/yaw binary angles out.
// ----------------------------------------------------------------------------
// One quaternion word goes in, one Euler word comes out, in order. The unit is
// a fixed pipeline that takes a new word every clock while the output is not
// stalled. Four stages form the product terms, saturate the sums and build
// 1 - s^2 for pitch; 28 stages take the square root for the asin cosine one
// bit at a time; each of three CORDIC units then spends three stages on
// magnitude and normalization, one stage per iteration and two on quadrant
// fix-up and rounding to 16-bit angles. The whole pipe advances together
// whenever the output register is empty or being taken, so quat_ready follows
// euler_ready when the pipe is full. Pitch is forced to plus or minus half pi,
// with pitch_clamped set, when the magnitude of its term reaches one. The
// quaternion is used as given, not normalized.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quat_valid,
	output logic               quat_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               euler_valid,
	input  logic               euler_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_clamped
);

	logic en;

	// stage 1: raw products
	term_t p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wy_s1, p_zx_s1, p_wz_s1, p_xy_s1, p_zz_s1;
	logic  v_s1;

	// stage 2: saturated terms
	term_t sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	logic  v_s2;

	// stage 3: pitch magnitude and clamp decision
	side_t       side_s3;
	logic [26:0] s1_s3;
	logic        v_s3;

	// stage 4: radicand (1 - s)(1 + s)
	side_t          side_s4;
	logic [RAD_W-1:0] rad_s4;
	logic           v_s4;

	term_t       asp_c;
	logic [27:0] dm_c, dp_c;

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	logic               roll_valid;
	logic signed [15:0] roll_raw, pitch_raw, yaw_raw;
	pflag_t             pitch_flag;

	// advance when the output register is empty or being taken
	assign en         = !euler_valid || euler_ready;
	assign quat_ready = en;

	assign asp_c = sp_s2[31] ? -sp_s2 : sp_s2;
	assign dm_c  = 28'(TERM_ONE) - {1'b0, s1_s3};
	assign dp_c  = 28'(TERM_ONE) + {1'b0, s1_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= quat_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;

			sr_s2 <= sat_add(p_wx_s1, p_yz_s1);
			cr_s2 <= TERM_ONE - sat_add(p_xx_s1, p_yy_s1);
			sp_s2 <= sat_add(p_wy_s1, -p_zx_s1);
			sy_s2 <= sat_add(p_wz_s1, p_xy_s1);
			cy_s2 <= TERM_ONE - sat_add(p_yy_s1, p_zz_s1);

			// clamp when |s| reaches one; hold the signed magnitude for the CORDIC
			side_s3.sr         <= sr_s2;
			side_s3.cr         <= cr_s2;
			side_s3.sy         <= sy_s2;
			side_s3.cy         <= cy_s2;
			side_s3.ss         <= sp_s2[31] ? -term_t'({5'b0, asp_c[26:0]})
			                                :  term_t'({5'b0, asp_c[26:0]});
			side_s3.flag.clamp <= (asp_c >= TERM_ONE);
			side_s3.flag.neg   <= sp_s2[31];
			s1_s3              <= asp_c[26:0];

			side_s4 <= side_s3;
			rad_s4  <= RAD_W'(dm_c * dp_c);
		end
	end

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.radicand  (rad_s4),
		.side_in   (side_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	qte_cordic u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (sq_side.sr),
		.x_in      (sq_side.cr),
		.flag_in   ('0),
		.out_valid (roll_valid),
		.angle     (roll_raw),
		.flag_out  ()
	);

	qte_cordic u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (sq_side.ss),
		.x_in      (term_t'({4'b0, sq_root})),
		.flag_in   (sq_side.flag),
		.out_valid (),
		.angle     (pitch_raw),
		.flag_out  (pitch_flag)
	);

	qte_cordic u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.y_in      (sq_side.sy),
		.x_in      (sq_side.cy),
		.flag_in   ('0),
		.out_valid (),
		.angle     (yaw_raw),
		.flag_out  ()
	);

	// the last CORDIC register is the output register
	assign euler_valid   = roll_valid;
	assign roll_angle    = roll_raw;
	assign yaw_angle     = yaw_raw;
	assign pitch_clamped = pitch_flag.clamp;
	assign pitch_angle   = pitch_flag.clamp ? (pitch_flag.neg ? PITCH_DOWN : PITCH_UP)
	                                        : pitch_raw;

`ifndef SYNTHESIS
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && pitch_clamped |->
			(pitch_angle == PITCH_UP || pitch_angle == PITCH_DOWN))
		else $error("clamped pitch is not half pi");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> (pitch_angle <= PITCH_UP && pitch_angle >= -PITCH_UP))
		else $error("pitch beyond half pi");
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid && !euler_ready |-> !quat_ready)
		else $error("input taken while output stalled");
`endif

endmodule
